/* rtl/core/ifhr_pkg.sv */
package ifhr_pkg;

  localparam int WORD_W     = 32;
  localparam int MAC_W      = 48;
  localparam int IHL_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  // smallest legal IHL (20-byte header)
  localparam logic [IHL_W-1:0] IHL_MIN = 4'd5;

  // header word positions with special handling
  localparam int WORD_IDX_TTL = 2;
  localparam int WORD_IDX_DST = 4;

  // register indexes, paddr[5:3]
  localparam logic [2:0] REG_A_NET  = 3'd0;
  localparam logic [2:0] REG_A_MASK = 3'd1;
  localparam logic [2:0] REG_A_NHOP = 3'd2;
  localparam logic [2:0] REG_A_PMAC = 3'd3;
  localparam logic [2:0] REG_B_NET  = 3'd4;
  localparam logic [2:0] REG_B_MASK = 3'd5;
  localparam logic [2:0] REG_B_NHOP = 3'd6;
  localparam logic [2:0] REG_B_PMAC = 3'd7;

  // register reset values
  localparam logic [WORD_W-1:0] RST_A_NET  = 32'd3232236032;
  localparam logic [WORD_W-1:0] RST_A_MASK = 32'd4294967040;
  localparam logic [MAC_W-1:0]  RST_A_NHOP = 48'd52232155744;
  localparam logic [MAC_W-1:0]  RST_A_PMAC = 48'd0;
  localparam logic [WORD_W-1:0] RST_B_NET  = 32'd3232235776;
  localparam logic [WORD_W-1:0] RST_B_MASK = 32'd4294967040;
  localparam logic [MAC_W-1:0]  RST_B_NHOP = 48'd52229469506;
  localparam logic [MAC_W-1:0]  RST_B_PMAC = 48'd0;

  typedef struct packed {
    logic [WORD_W-1:0] network;
    logic [WORD_W-1:0] mask;
    logic [MAC_W-1:0]  nhop_mac;
    logic [MAC_W-1:0]  port_mac;
  } route_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;     // input beat this cycle
    logic do_match;    // route lookup, latch result
    logic emit_clear;  // rewind emit pointer
    logic emit_fetch;  // read buffer at emit pointer
    logic emit_next;   // advance emit pointer
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr_done;    // current input beat completes a header
    logic route_hit;   // some route matches the stored destination
    logic emit_last;   // emit pointer sits on the final word
  } dp_status_t;

  // one's-complement end-around carry of a 17-bit sum (sum <= 0x1FFFE)
  function automatic logic [15:0] fold16(input logic [16:0] s);
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

/* rtl/core/ifhr_if.sv */
interface ifhr_in_if;
  import ifhr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] header_word;
  logic              start_req;

  modport source(output valid, header_word, start_req, input ready);
  modport sink(input valid, header_word, start_req, output ready);
endinterface

interface ifhr_out_if;
  import ifhr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic              last_word;
  logic              out_port;
  logic [MAC_W-1:0]  dst_mac;
  logic [MAC_W-1:0]  src_mac;

  modport source(output valid, out_word, last_word, out_port, dst_mac, src_mac, input ready);
  modport sink(input valid, out_word, last_word, out_port, dst_mac, src_mac, output ready);
endinterface

/* rtl/core/ipv4_forward_header_rewrite.sv */
// IPv4 forwarding header rewrite. Header words enter one per cycle on in_bus
// while the block is collecting, start_req on the first; IHL sets the length,
// and a start word with IHL below 5 or above MAX_HEADER_WORDS is dropped. A
// start word mid-header restarts collection. Words outside a header are taken
// and ignored. In the cycle after the last word the destination address is
// looked up against the two routes (first match wins); on a hit the header
// leaves on out_bus with TTL decremented and the checksum recomputed, tagged
// with the route's port, next-hop MAC and port MAC; on a miss nothing leaves.
// Each result beat is a buffer read followed by a present state that waits
// for out_ready; input is held off while a header is being sent. The route
// registers sit at byte address 8*i on the 64-bit cfg port and should be
// written only while the block is idle.
module ipv4_forward_header_rewrite #(
  parameter int MAX_HEADER_WORDS = 15,
  parameter int ROUTE_COUNT      = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ifhr_in_if.sink                            in_bus,
  ifhr_out_if.source                         out_bus,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ifhr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ifhr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ifhr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import ifhr_pkg::*;

  route_t [1:0] routes;
  dp_cmd_t      cmd;
  dp_status_t   status;

  ifhr_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .routes (routes)
  );

  ifhr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .out_valid(out_bus.valid),
    .out_ready(out_bus.ready),
    .cmd      (cmd),
    .status   (status)
  );

  ifhr_dp #(
    .MAX_HEADER_WORDS(MAX_HEADER_WORDS),
    .ROUTE_COUNT     (ROUTE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .header_word(in_bus.header_word),
    .start_req  (in_bus.start_req),
    .routes     (routes),
    .out_word   (out_bus.out_word),
    .last_word  (out_bus.last_word),
    .out_port   (out_bus.out_port),
    .dst_mac    (out_bus.dst_mac),
    .src_mac    (out_bus.src_mac)
  );

endmodule

/* rtl/core/ifhr_ram.sv */
module ifhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ifhr_cfg.sv */
module ifhr_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ifhr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ifhr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ifhr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output ifhr_pkg::route_t [1:0]             routes
);
  import ifhr_pkg::*;

  route_t [1:0] route_r;
  logic         wr_en;
  logic [2:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // route table registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r[0].network  <= RST_A_NET;
      route_r[0].mask     <= RST_A_MASK;
      route_r[0].nhop_mac <= RST_A_NHOP;
      route_r[0].port_mac <= RST_A_PMAC;
      route_r[1].network  <= RST_B_NET;
      route_r[1].mask     <= RST_B_MASK;
      route_r[1].nhop_mac <= RST_B_NHOP;
      route_r[1].port_mac <= RST_B_PMAC;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_A_NET:  route_r[0].network  <= pwdata[WORD_W-1:0];
        REG_A_MASK: route_r[0].mask     <= pwdata[WORD_W-1:0];
        REG_A_NHOP: route_r[0].nhop_mac <= pwdata[MAC_W-1:0];
        REG_A_PMAC: route_r[0].port_mac <= pwdata[MAC_W-1:0];
        REG_B_NET:  route_r[1].network  <= pwdata[WORD_W-1:0];
        REG_B_MASK: route_r[1].mask     <= pwdata[WORD_W-1:0];
        REG_B_NHOP: route_r[1].nhop_mac <= pwdata[MAC_W-1:0];
        REG_B_PMAC: route_r[1].port_mac <= pwdata[MAC_W-1:0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_A_NET:  prdata = CFG_DATA_W'(route_r[0].network);
      REG_A_MASK: prdata = CFG_DATA_W'(route_r[0].mask);
      REG_A_NHOP: prdata = CFG_DATA_W'(route_r[0].nhop_mac);
      REG_A_PMAC: prdata = CFG_DATA_W'(route_r[0].port_mac);
      REG_B_NET:  prdata = CFG_DATA_W'(route_r[1].network);
      REG_B_MASK: prdata = CFG_DATA_W'(route_r[1].mask);
      REG_B_NHOP: prdata = CFG_DATA_W'(route_r[1].nhop_mac);
      REG_B_PMAC: prdata = CFG_DATA_W'(route_r[1].port_mac);
      default:    prdata = '0;
    endcase
  end

  assign routes = route_r;

endmodule

/* rtl/core/ifhr_dp.sv */
module ifhr_dp #(
  parameter int MAX_HEADER_WORDS = 15,
  parameter int ROUTE_COUNT      = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ifhr_pkg::dp_cmd_t              cmd,
  output ifhr_pkg::dp_status_t           status,
  input  logic [ifhr_pkg::WORD_W-1:0]    header_word,
  input  logic                           start_req,
  input  ifhr_pkg::route_t [1:0]         routes,
  output logic [ifhr_pkg::WORD_W-1:0]    out_word,
  output logic                           last_word,
  output logic                           out_port,
  output logic [ifhr_pkg::MAC_W-1:0]     dst_mac,
  output logic [ifhr_pkg::MAC_W-1:0]     src_mac
);
  import ifhr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_HEADER_WORDS + 1);
  localparam int ADDR_W = $clog2(MAX_HEADER_WORDS);

  // header collection state
  logic              in_hdr_r;
  logic [CNT_W-1:0]  count_r;
  logic [IHL_W-1:0]  len_r;
  logic [15:0]       sum_r;
  logic [WORD_W-1:0] word2_r;
  logic [WORD_W-1:0] dst_r;

  // lookup result and emit pointer
  logic              port_r;
  logic [MAC_W-1:0]  dmac_r;
  logic [MAC_W-1:0]  smac_r;
  logic [WORD_W-1:0] new_word2_r;
  logic [CNT_W-1:0]  emit_idx_r;

  logic [IHL_W-1:0]  ihl;
  logic              ihl_ok;
  logic              active;
  logic [CNT_W-1:0]  base_cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [IHL_W-1:0]  eff_len;
  logic              is_last;
  logic [15:0]       base_sum;
  logic [15:0]       contrib;
  logic [15:0]       sum_add;
  logic [7:0]        ttl_dec;
  logic              store_we;
  logic [1:0]        hits;
  logic              sel_port;
  logic [WORD_W-1:0] rd_word;
  logic [CNT_W-1:0]  emit_inc;

  // input beat decode
  assign ihl      = header_word[27:24];
  assign ihl_ok   = (ihl >= IHL_MIN) && (ihl <= IHL_W'(MAX_HEADER_WORDS));
  assign active   = start_req ? ihl_ok : in_hdr_r;
  assign base_cnt = start_req ? '0 : count_r;
  assign cnt_inc  = base_cnt + CNT_W'(1);
  assign eff_len  = start_req ? ihl : len_r;
  assign is_last  = (IHL_W'(cnt_inc) == eff_len);
  assign store_we = cmd.take_in && active;

  // checksum contribution; TTL word counts as new TTL plus protocol
  assign ttl_dec  = header_word[31:24] - 8'd1;
  assign base_sum = start_req ? 16'd0 : sum_r;
  always_comb begin
    if (base_cnt == CNT_W'(WORD_IDX_TTL)) begin
      contrib = {ttl_dec, header_word[23:16]};
    end else begin
      contrib = fold16({1'b0, header_word[31:16]} + {1'b0, header_word[15:0]});
    end
  end
  assign sum_add = fold16({1'b0, base_sum} + {1'b0, contrib});

  assign status.hdr_done = active && is_last;

  // collection registers; a bad start word clears and closes the header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hdr_r <= 1'b0;
      count_r  <= '0;
      len_r    <= '0;
      sum_r    <= '0;
    end else if (cmd.take_in) begin
      if (start_req) begin
        len_r <= ihl;
      end
      if (active) begin
        sum_r    <= sum_add;
        count_r  <= cnt_inc;
        in_hdr_r <= !is_last;
      end else if (start_req) begin
        count_r  <= '0;
        sum_r    <= '0;
        in_hdr_r <= 1'b0;
      end
    end
  end

  // capture TTL word and destination as they pass
  always_ff @(posedge clk) begin
    if (store_we && base_cnt == CNT_W'(WORD_IDX_TTL)) begin
      word2_r <= header_word;
    end
    if (store_we && base_cnt == CNT_W'(WORD_IDX_DST)) begin
      dst_r <= header_word;
    end
  end

  // header buffer
  ifhr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_HEADER_WORDS)
  ) u_buf (
    .clk  (clk),
    .we   (store_we),
    .waddr(base_cnt[ADDR_W-1:0]),
    .wdata(header_word),
    .re   (cmd.emit_fetch),
    .raddr(emit_idx_r[ADDR_W-1:0]),
    .rdata(rd_word)
  );

  // route match, first entry wins
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      hits[r] = (r < ROUTE_COUNT) &&
                ((dst_r & routes[r].mask) == (routes[r].network & routes[r].mask));
    end
  end
  assign sel_port         = !hits[0];
  assign status.route_hit = |hits;

  // latch lookup result and rewritten TTL/checksum word
  always_ff @(posedge clk) begin
    if (cmd.do_match) begin
      port_r      <= sel_port;
      dmac_r      <= routes[sel_port].nhop_mac;
      smac_r      <= routes[sel_port].port_mac;
      new_word2_r <= {word2_r[31:24] - 8'd1, word2_r[23:16], ~sum_r};
    end
  end

  // emit pointer
  assign emit_inc = emit_idx_r + CNT_W'(1);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_clear) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_next) begin
      emit_idx_r <= emit_inc;
    end
  end
  assign status.emit_last = (IHL_W'(emit_inc) == len_r);

  // result beat
  assign out_word  = (emit_idx_r == CNT_W'(WORD_IDX_TTL)) ? new_word2_r : rd_word;
  assign last_word = status.emit_last;
  assign out_port  = port_r;
  assign dst_mac   = dmac_r;
  assign src_mac   = smac_r;

endmodule

/* rtl/core/ifhr_ctrl.sv */
module ifhr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ifhr_pkg::dp_cmd_t     cmd,
  input  ifhr_pkg::dp_status_t  status
);
  import ifhr_pkg::*;

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_MATCH   = 2'd1;
  localparam logic [1:0] S_FETCH   = 2'd2;
  localparam logic [1:0] S_SHOW    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_beat;

  assign in_ready  = (state_r == S_COLLECT);
  assign out_valid = (state_r == S_SHOW);
  assign in_beat   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.take_in    = in_beat;
    unique case (state_r)
      S_COLLECT: begin
        if (in_beat && status.hdr_done) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.do_match   = 1'b1;
        cmd.emit_clear = 1'b1;
        state_nxt      = status.route_hit ? S_FETCH : S_COLLECT;
      end
      S_FETCH: begin
        cmd.emit_fetch = 1'b1;
        state_nxt      = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (status.emit_last) begin
            state_nxt = S_COLLECT;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_FETCH;
          end
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/ifhr_checker.sv */
module ifhr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        last_word
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(last_word))
    else $error("result beat changed while stalled");

  // input is held off while a header is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during emission");

  // final beat ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("burst continued past last word");

  // reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ipv4_forward_header_rewrite ifhr_checker u_ifhr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_word (out_bus.out_word),
  .last_word(out_bus.last_word)
);

/* dv/tb_ipv4_forward_header_rewrite.sv */
module tb_ipv4_forward_header_rewrite;
  timeunit 1ns;
  timeprecision 1ps;

  import ifhr_pkg::*;

  localparam int          RESET_CYCLES = 6;
  localparam int          DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          PHASE_WORDS  = 120;
  localparam int          MAX_PRINTS   = 30;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              port;
    logic [MAC_W-1:0]  dmac;
    logic [MAC_W-1:0]  smac;
  } hdr_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ifhr_in_if  in_bus();
  ifhr_out_if out_bus();

  ipv4_forward_header_rewrite i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the route table and the header collector
  route_t          routes [2];
  logic [31:0]     hdr_words [16];
  logic [3:0]      hdr_count;
  logic [3:0]      hdr_len;
  logic [31:0]     csum_acc;
  logic            hdr_open;
  hdr_beat_t       expected_beats [$];

  int              send_idle_pct;
  int              recv_idle_pct;
  int              mismatches;
  int              words_sent;
  int              beats_checked;
  int              hdrs_forwarded;
  int              hdrs_missed;
  int              hdrs_dropped;
  int unsigned     cycle_count;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // one's-complement add with end-around carry
  function automatic logic [31:0] ones_add(logic [31:0] acc, logic [31:0] v);
    logic [31:0] s;
    s = acc + (v & 32'h0000_FFFF);
    return (s & 32'h0000_FFFF) + (s >> 16);
  endfunction

  function automatic void set_route_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      REG_A_NET:  routes[0].network  = v[31:0];
      REG_A_MASK: routes[0].mask     = v[31:0];
      REG_A_NHOP: routes[0].nhop_mac = v[47:0];
      REG_A_PMAC: routes[0].port_mac = v[47:0];
      REG_B_NET:  routes[1].network  = v[31:0];
      REG_B_MASK: routes[1].mask     = v[31:0];
      REG_B_NHOP: routes[1].nhop_mac = v[47:0];
      REG_B_PMAC: routes[1].port_mac = v[47:0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] route_reg(logic [2:0] idx);
    case (idx)
      REG_A_NET:  return {32'd0, routes[0].network};
      REG_A_MASK: return {32'd0, routes[0].mask};
      REG_A_NHOP: return {16'd0, routes[0].nhop_mac};
      REG_A_PMAC: return {16'd0, routes[0].port_mac};
      REG_B_NET:  return {32'd0, routes[1].network};
      REG_B_MASK: return {32'd0, routes[1].mask};
      REG_B_NHOP: return {16'd0, routes[1].nhop_mac};
      default:    return {16'd0, routes[1].port_mac};
    endcase
  endfunction

  // collect one header word; on a completed, routed header queue the rewrite
  function automatic void predict_rewrite(logic [31:0] w, logic s);
    logic [31:0] part;
    logic [31:0] sum;
    logic [31:0] word2;
    int          hit;
    hdr_beat_t   b;
    if (s) begin
      hdr_count = '0;
      csum_acc  = '0;
      hdr_len   = w[27:24];
      if (w[27:24] < IHL_MIN) begin
        hdr_open = 1'b0;
        hdrs_dropped++;
        return;
      end
      hdr_open = 1'b1;
    end else if (!hdr_open) begin
      return;
    end

    hdr_words[hdr_count] = w;
    if (hdr_count == WORD_IDX_TTL)
      part = ones_add(32'd0, {16'd0, w[31:24] - 8'd1, w[23:16]});
    else
      part = ones_add(ones_add(32'd0, w >> 16), w & 32'h0000_FFFF);
    csum_acc  = ones_add(csum_acc, part);
    hdr_count = hdr_count + 4'd1;
    if (hdr_count != hdr_len)
      return;
    hdr_open = 1'b0;

    // first matching route wins
    hit = -1;
    for (int r = 0; r < 2; r++)
      if (hit < 0 && (hdr_words[WORD_IDX_DST] & routes[r].mask) ==
                     (routes[r].network & routes[r].mask))
        hit = r;
    if (hit < 0) begin
      hdrs_missed++;
      return;
    end
    hdrs_forwarded++;

    sum   = (csum_acc & 32'h0000_FFFF) + (csum_acc >> 16);
    sum   = (sum & 32'h0000_FFFF) + (sum >> 16);
    word2 = {hdr_words[WORD_IDX_TTL][31:24] - 8'd1, hdr_words[WORD_IDX_TTL][23:16],
             ~sum[15:0]};
    for (int i = 0; i < hdr_len; i++) begin
      b.word = (i == WORD_IDX_TTL) ? word2 : hdr_words[i];
      b.last = (i == hdr_len - 1);
      b.port = hit[0];
      b.dmac = routes[hit].nhop_mac;
      b.smac = routes[hit].port_mac;
      expected_beats.push_back(b);
    end
  endfunction

  // input beat with random lead-in gaps; valid stays high across back-to-back beats
  task automatic send_beat(input logic [31:0] w, input logic s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid       = 1'b1;
    in_bus.header_word = w;
    in_bus.start_req   = s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_rewrite(w, s);
  endtask

  // sends the first nsend words of an ihl-word header
  task automatic send_header(input int ihl, input logic [7:0] ttl, input logic [31:0] dst,
                             input fill_t fill, input int nsend);
    logic [31:0] w;
    for (int i = 0; i < nsend; i++) begin
      case (fill)
        FILL_ZERO: w = 32'd0;
        FILL_ONES: w = 32'hFFFF_FFFF;
        default:   w = $urandom();
      endcase
      if (i == 0) w[27:24] = ihl[3:0];
      if (i == WORD_IDX_TTL) w[31:24] = ttl;
      if (i == WORD_IDX_DST) w = dst;
      send_beat(w, i == 0);
      words_sent++;
    end
  endtask

  // stop input, wait for every expected beat, then let the lookup settle
  task automatic drain_block();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    set_route_reg(idx, v);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [63:0] keep;
    keep = (idx == REG_A_NHOP || idx == REG_A_PMAC || idx == REG_B_NHOP ||
            idx == REG_B_PMAC) ? 64'h0000_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx, 3'b000};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if ((cfg_prdata & keep) !== route_reg(idx))
      report_mismatch($sformatf("reg %0d read %h want %h", idx, cfg_prdata & keep,
                                route_reg(idx)));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic program_route(input int r, input logic [31:0] net, input logic [31:0] mask,
                               input logic [47:0] nhop, input logic [47:0] pmac);
    logic [2:0] i_net, i_mask, i_nhop, i_pmac;
    i_net  = (r == 0) ? REG_A_NET  : REG_B_NET;
    i_mask = (r == 0) ? REG_A_MASK : REG_B_MASK;
    i_nhop = (r == 0) ? REG_A_NHOP : REG_B_NHOP;
    i_pmac = (r == 0) ? REG_A_PMAC : REG_B_PMAC;
    write_reg(i_net, {32'd0, net});
    write_reg(i_mask, {32'd0, mask});
    write_reg(i_nhop, {16'd0, nhop});
    write_reg(i_pmac, {16'd0, pmac});
    check_reg(i_net);
    check_reg(i_mask);
    check_reg(i_nhop);
    check_reg(i_pmac);
  endtask

  function automatic logic [47:0] rand_mac();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return r64[47:0];
  endfunction

  function automatic logic [31:0] dst_in_route(int r);
    return (routes[r].network & routes[r].mask) | ($urandom() & ~routes[r].mask);
  endfunction

  // reset values, TTL wrap at zero, all-ones and all-zero headers, a miss
  task automatic test_default_routes();
    for (int i = 0; i < 8; i++) check_reg(i[2:0]);
    send_header(5, 8'h00, RST_A_NET | 32'h0000_0011, FILL_ZERO, 5);
    send_header(15, 8'hFF, RST_B_NET | 32'h0000_00FE, FILL_ONES, 15);
    send_header(5, 8'h01, 32'h0A00_0001, FILL_RANDOM, 5);
    drain_block();
  endtask

  // short IHL dropped, stray words ignored, then a clean header still works
  task automatic test_dropped_and_stray();
    send_beat(32'h0000_0000, 1'b1);
    send_beat(32'hF4FF_FFFF, 1'b1);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat($urandom(), 1'b0);
    send_header(5, 8'h40, RST_A_NET, FILL_RANDOM, 5);
    drain_block();
  endtask

  // a start word in the middle of a header discards the partial one
  task automatic test_restart();
    send_header(9, 8'h22, RST_A_NET | 32'h1, FILL_RANDOM, 3);
    send_header(6, 8'h80, RST_B_NET | 32'h1, FILL_RANDOM, 6);
    send_header(5, 8'h10, RST_B_NET | 32'h2, FILL_RANDOM, 4);
    send_header(5, 8'h11, RST_A_NET | 32'h3, FILL_RANDOM, 5);
    drain_block();
  endtask

  // zero and all-ones route settings, route A priority, catch-all route B
  task automatic test_config_extremes();
    program_route(0, 32'd0, 32'd0, 48'd0, 48'd0);
    program_route(1, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_header(5, 8'h05, $urandom(), FILL_RANDOM, 5);
    drain_block();
    program_route(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    program_route(1, 32'hFFFF_FFFF, 32'd0, 48'h0000_0000_0001, 48'h8000_0000_0000);
    send_header(5, 8'h01, 32'hFFFF_FFFF, FILL_RANDOM, 5);
    send_header(7, 8'h00, 32'h1234_5678, FILL_RANDOM, 7);
    drain_block();
  endtask

  task automatic random_phase(input int s_idle, input int r_idle);
    int          ihl;
    int          sent;
    int          pick;
    int          plen;
    logic [7:0]  ttl;
    logic [31:0] dst;
    logic [31:0] w;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int r = 0; r < 2; r++) begin
      plen = $urandom_range(28, 4);
      program_route(r, $urandom(), 32'hFFFF_FFFF << (32 - plen), rand_mac(), rand_mac());
    end
    sent = 0;
    while (sent < PHASE_WORDS) begin
      ihl  = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 5);
      pick = $urandom_range(9);
      ttl  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'h01 : 8'($urandom());
      pick = $urandom_range(9);
      dst  = (pick < 4) ? dst_in_route(0) : (pick < 7) ? dst_in_route(1) : $urandom();
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_header(ihl, ttl, dst, FILL_RANDOM, ihl);
        sent += ihl;
      end else if (pick < 88) begin
        // broken header, then a full one over it
        send_header(ihl, ttl, dst, FILL_RANDOM, $urandom_range(ihl - 1, 1));
        send_header(ihl, ttl, dst, FILL_RANDOM, ihl);
        sent += ihl;
      end else if (pick < 94) begin
        w = $urandom();
        w[27:24] = 4'($urandom_range(4));
        send_beat(w, 1'b1);
      end else begin
        send_beat($urandom(), 1'b0);
      end
    end
    drain_block();
  endtask

  task automatic test_random_traffic();
    random_phase(19, 65);
    random_phase(65, 19);
    random_phase(0, 0);
  endtask

  // receiver back-pressure
  always @(negedge clk) out_bus.ready = ($urandom_range(99) >= recv_idle_pct);

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin : check_out
    hdr_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat word %h", out_bus.out_word));
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (out_bus.out_word !== want.word)
          report_mismatch($sformatf("out_word %h want %h", out_bus.out_word, want.word));
        if (out_bus.last_word !== want.last)
          report_mismatch($sformatf("last_word %b want %b", out_bus.last_word, want.last));
        if (out_bus.out_port !== want.port)
          report_mismatch($sformatf("out_port %b want %b", out_bus.out_port, want.port));
        if (out_bus.dst_mac !== want.dmac)
          report_mismatch($sformatf("dst_mac %h want %h", out_bus.dst_mac, want.dmac));
        if (out_bus.src_mac !== want.smac)
          report_mismatch($sformatf("src_mac %h want %h", out_bus.src_mac, want.smac));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
             expected_beats.size());
    $display("** ipv4_forward_header_rewrite: FAILED **");
    $finish;
  end

  initial begin
    cycle_count        = 0;
    mismatches         = 0;
    words_sent         = 0;
    beats_checked      = 0;
    hdrs_forwarded     = 0;
    hdrs_missed        = 0;
    hdrs_dropped       = 0;
    send_idle_pct      = 19;
    recv_idle_pct      = 65;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.header_word = '0;
    in_bus.start_req   = 1'b0;
    out_bus.ready      = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    hdr_count          = '0;
    hdr_len            = '0;
    csum_acc           = '0;
    hdr_open           = 1'b0;
    routes[0]          = '{RST_A_NET, RST_A_MASK, RST_A_NHOP, RST_A_PMAC};
    routes[1]          = '{RST_B_NET, RST_B_MASK, RST_B_NHOP, RST_B_PMAC};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_routes();
    test_dropped_and_stray();
    test_restart();
    test_config_extremes();
    test_random_traffic();

    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
    $display("sent %0d header words: %0d headers forwarded, %0d missed, %0d dropped",
             words_sent, hdrs_forwarded, hdrs_missed, hdrs_dropped);
    $display("checked %0d result beats over %0d cycles, %0d mismatches",
             beats_checked, cycle_count, mismatches);
    if (mismatches == 0)
      $display("** ipv4_forward_header_rewrite: PASSED **");
    else
      $display("** ipv4_forward_header_rewrite: FAILED **");
    $finish;
  end

endmodule
